// File: sv/prqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package prqs_pkg;
   localparam int GroupBits = 32;
   typedef enum logic [2:0] {
      CMD_ENQUEUE  = 3'd0,
      CMD_REQUEUE  = 3'd1,
      CMD_REMOVE   = 3'd2,
      CMD_YIELD    = 3'd3,
      CMD_SCHEDULE = 3'd4
   } command_type;
   typedef struct packed {
      logic [2:0] command;
      logic [7:0] task_id;
      logic [7:0] task_priority;
      logic [7:0] old_priority;
      logic       current_running;
      logic       task_ok;
      logic       prio_ok;
      logic       oldp_ok;
   } item_type;
endpackage
`default_nettype wire

// File: sv/priority_ready_queue_scheduler.sv
// Priority ready-queue scheduler. One response follows each request transaction. The back end
// takes a command, reads the links, carries out up to five memory read and write steps for the
// links and heads (a requeue needs the most), then scans the ready bitmap at one 32-bit group
// per cycle, from the top group down to the first group with a ready task, and last reads the
// head, updates the current task and presents the response, which a response stall can hold. A
// two-entry queue lets new requests be taken while a command is being carried out.
`timescale 1ns / 1ps
`default_nettype none
module priority_ready_queue_scheduler #(
   parameter int TASK_COUNT      = 64,
   parameter int PRIORITY_GROUPS = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_command,
   input  wire logic [5:0] req_task_id,
   input  wire logic [7:0] req_task_priority,
   input  wire logic [7:0] req_old_priority,
   input  wire logic       req_current_running,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_ready_found,
   output logic [7:0]      rsp_highest_priority,
   output logic [5:0]      rsp_next_task,
   output logic            rsp_switch_task,
   output logic            rsp_enter_idle,
   output logic [5:0]      rsp_current_task,
   output logic            rsp_current_valid
);
   logic q_valid, q_take;
   prqs_pkg::item_type q_item;

   prqs_front #(.TASK_COUNT(TASK_COUNT), .PRIORITY_GROUPS(PRIORITY_GROUPS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_task_id,
      .req_task_priority, .req_old_priority, .req_current_running,
      .q_valid, .q_take, .q_item
   );

   prqs_back #(.TASK_COUNT(TASK_COUNT), .PRIORITY_GROUPS(PRIORITY_GROUPS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_item, .rsp_valid, .rsp_stall,
      .rsp_ready_found, .rsp_highest_priority, .rsp_next_task, .rsp_switch_task,
      .rsp_enter_idle, .rsp_current_task, .rsp_current_valid
   );
endmodule
`default_nettype wire

// File: sv/prqs_front.sv
`timescale 1ns / 1ps
`default_nettype none
module prqs_front #(
   parameter int TASK_COUNT      = 64,
   parameter int PRIORITY_GROUPS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_command,
   input  wire logic [5:0]        req_task_id,
   input  wire logic [7:0]        req_task_priority,
   input  wire logic [7:0]        req_old_priority,
   input  wire logic              req_current_running,
   output logic                   q_valid,
   input  wire logic              q_take,
   output prqs_pkg::item_type     q_item
);
   localparam int Slots = PRIORITY_GROUPS * prqs_pkg::GroupBits;
   localparam int Depth = 2;
   prqs_pkg::item_type fifo_ff [Depth];
   logic [1:0] count_ff, count_in;
   logic       wptr_ff, rptr_ff;
   prqs_pkg::item_type cls;
   logic push, pop;

   always_comb begin
      cls.command         = req_command;
      cls.task_id         = {2'b00, req_task_id};
      cls.task_priority   = req_task_priority;
      cls.old_priority    = req_old_priority;
      cls.current_running = req_current_running;
      cls.task_ok         = 32'(req_task_id) < TASK_COUNT;
      cls.prio_ok         = 32'(req_task_priority) < Slots;
      cls.oldp_ok         = 32'(req_old_priority) < Slots;
   end

   assign req_stall = count_ff == 2'(Depth);
   assign push      = req_valid && !req_stall;
   assign pop       = q_take && q_valid;
   assign q_valid   = count_ff != 2'd0;
   assign q_item    = fifo_ff[rptr_ff];
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wptr_ff] <= cls;
      end
      if (reset) begin
         count_ff <= 2'd0;
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
      end
   end
endmodule
`default_nettype wire

// File: sv/prqs_back.sv
`timescale 1ns / 1ps
`default_nettype none
module prqs_back #(
   parameter int TASK_COUNT      = 64,
   parameter int PRIORITY_GROUPS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_take,
   input  wire prqs_pkg::item_type q_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_ready_found,
   output logic [7:0]             rsp_highest_priority,
   output logic [5:0]             rsp_next_task,
   output logic                   rsp_switch_task,
   output logic                   rsp_enter_idle,
   output logic [5:0]             rsp_current_task,
   output logic                   rsp_current_valid
);
   localparam int Slots = PRIORITY_GROUPS * prqs_pkg::GroupBits;
   localparam int TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int PW = $clog2(Slots) > 0 ? $clog2(Slots) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_RD1, S_RD2, S_ROT, S_UNL, S_ENQ_RD, S_ENQ_TL, S_ENQ_WR1, S_ENQ_WR2,
      S_FIND, S_HEAD, S_SCHED, S_OUT
   } state_type;

   state_type state_ff;
   prqs_pkg::item_type it_ff;
   logic [Slots-1:0] bitmap_ff;
   logic [TW-1:0] head_mem [Slots];
   logic [TW-1:0] next_mem [TASK_COUNT];
   logic [TW-1:0] prev_mem [TASK_COUNT];
   logic [TW-1:0] t_nx_ff, t_pv_ff, hd_ff, tl_ff, nt_ff, run_task_ff;
   logic run_valid_ff, found_ff, sw_ff, idle_ff;
   logic [PW-1:0] hp_ff, scan_ff;
   logic [7:0] grp_ff;

   logic [TW-1:0] tid;
   logic [PW-1:0] prio, oldp;
   assign tid  = it_ff.task_id[TW-1:0];
   assign prio = it_ff.task_priority[PW-1:0];
   assign oldp = it_ff.old_priority[PW-1:0];
   assign q_take = state_ff == S_IDLE && q_valid;

   logic [PW-1:0] up;
   assign up = (it_ff.command == prqs_pkg::CMD_REQUEUE) ? oldp : prio;

   logic [31:0] word;
   logic wfound;
   logic [4:0] wbit;
   always_comb begin
      word = bitmap_ff[scan_ff[PW-1:0] & ~PW'(31) +: 32];
      wfound = 1'b0;
      wbit = 5'd0;
      for (int b = 0; b < 32; b++) begin
         if (word[b]) begin
            wfound = 1'b1;
            wbit = 5'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bitmap_ff    <= '0;
         run_task_ff  <= '0;
         run_valid_ff <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  it_ff    <= q_item;
                  state_ff <= S_RD1;
               end
            end
            S_RD1: begin
               t_nx_ff <= next_mem[tid];
               t_pv_ff <= prev_mem[tid];
               hd_ff   <= head_mem[up];
               state_ff <= S_FIND;
               case (it_ff.command)
                  prqs_pkg::CMD_ENQUEUE: begin
                     if (it_ff.task_ok && it_ff.prio_ok) state_ff <= S_ENQ_RD;
                  end
                  prqs_pkg::CMD_REQUEUE: begin
                     if (it_ff.task_ok && it_ff.prio_ok && it_ff.oldp_ok) begin
                        state_ff <= bitmap_ff[oldp] ? S_UNL : S_ENQ_RD;
                     end
                  end
                  prqs_pkg::CMD_REMOVE: begin
                     if (it_ff.task_ok && it_ff.prio_ok && bitmap_ff[prio]) state_ff <= S_UNL;
                  end
                  prqs_pkg::CMD_YIELD: begin
                     if (it_ff.prio_ok && bitmap_ff[prio]) state_ff <= S_RD2;
                  end
                  default: state_ff <= S_FIND;
               endcase
            end
            S_RD2: begin
               t_nx_ff  <= next_mem[hd_ff];
               state_ff <= S_ROT;
            end
            S_ROT: begin
               if (t_nx_ff != hd_ff) head_mem[prio] <= t_nx_ff;
               state_ff <= S_FIND;
            end
            S_UNL: begin
               if (t_nx_ff == tid) begin
                  bitmap_ff[up] <= 1'b0;
               end else begin
                  next_mem[t_pv_ff] <= t_nx_ff;
                  prev_mem[t_nx_ff] <= t_pv_ff;
                  if (hd_ff == tid) head_mem[up] <= t_nx_ff;
               end
               state_ff <= (it_ff.command == prqs_pkg::CMD_REQUEUE) ? S_ENQ_RD : S_FIND;
            end
            S_ENQ_RD: begin
               hd_ff    <= head_mem[prio];
               state_ff <= S_ENQ_TL;
            end
            S_ENQ_TL: begin
               // A requeued task is self-linked before it is appended.
               tl_ff <= (it_ff.command == prqs_pkg::CMD_REQUEUE && hd_ff == tid) ? tid
                                                                               : prev_mem[hd_ff];
               state_ff <= S_ENQ_WR1;
            end
            S_ENQ_WR1: begin
               if (!bitmap_ff[prio]) begin
                  head_mem[prio]  <= tid;
                  next_mem[tid]   <= tid;
                  prev_mem[tid]   <= tid;
                  bitmap_ff[prio] <= 1'b1;
                  state_ff        <= S_FIND;
               end else begin
                  next_mem[tid] <= hd_ff;
                  prev_mem[tid] <= tl_ff;
                  state_ff      <= S_ENQ_WR2;
               end
            end
            S_ENQ_WR2: begin
               next_mem[tl_ff] <= tid;
               prev_mem[hd_ff] <= tid;
               bitmap_ff[prio] <= 1'b1;
               state_ff <= S_FIND;
            end
            S_FIND: begin
               scan_ff  <= PW'(Slots - 1);
               grp_ff   <= 8'(PRIORITY_GROUPS);
               found_ff <= 1'b0;
               hp_ff    <= '0;
               state_ff <= S_HEAD;
            end
            S_HEAD: begin
               if (grp_ff == 8'd0 || found_ff) begin
                  nt_ff    <= found_ff ? head_mem[hp_ff] : '0;
                  state_ff <= S_SCHED;
               end else begin
                  if (wfound) begin
                     found_ff <= 1'b1;
                     hp_ff    <= (scan_ff & ~PW'(31)) | PW'(wbit);
                  end
                  scan_ff <= scan_ff - PW'(32);
                  grp_ff  <= grp_ff - 8'd1;
               end
            end
            S_SCHED: begin
               sw_ff   <= 1'b0;
               idle_ff <= 1'b0;
               if ((it_ff.command == prqs_pkg::CMD_YIELD ||
                    it_ff.command == prqs_pkg::CMD_SCHEDULE) && found_ff &&
                   !(run_valid_ff && it_ff.current_running)) begin
                  if (!run_valid_ff || nt_ff != run_task_ff) begin
                     run_task_ff <= nt_ff;
                     run_valid_ff <= 1'b1;
                     sw_ff <= 1'b1;
                  end else begin
                     run_task_ff <= '0;
                     run_valid_ff <= 1'b0;
                     idle_ff <= 1'b1;
                  end
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_ready_found      <= found_ff;
                  rsp_highest_priority <= 8'(hp_ff);
                  rsp_next_task        <= 6'(nt_ff);
                  rsp_switch_task      <= sw_ff;
                  rsp_enter_idle       <= idle_ff;
                  rsp_current_task     <= run_valid_ff ? 6'(run_task_ff) : 6'd0;
                  rsp_current_valid    <= run_valid_ff;
                  state_ff             <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: sv/prqs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module prqs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_ready_found,
   input wire logic [7:0] rsp_highest_priority,
   input wire logic [5:0] rsp_next_task,
   input wire logic       rsp_switch_task,
   input wire logic       rsp_enter_idle,
   input wire logic [5:0] rsp_current_task,
   input wire logic       rsp_current_valid
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_switch_task && rsp_enter_idle)) else $error("switch and idle");
   a_sw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switch_task |-> rsp_current_valid && rsp_ready_found &&
      rsp_current_task == rsp_next_task) else $error("switch target");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enter_idle |-> !rsp_current_valid && rsp_current_task == 6'd0)
      else $error("idle state");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_current_task))
      else $error("stalled response changed");
endmodule
bind priority_ready_queue_scheduler prqs_checker u_prqs_checker (.*);
`default_nettype wire
